// File: rtl/lcf_pkg.sv
// lcf_pkg: shared sizes, state and opcode types, exp constants and rounding helper
// used by lcf_act and lstm_cell_forward_step_core; no dependencies
package lcf_pkg;

   localparam int INPUT_LEN  = 16;
   localparam int HIDDEN_LEN = 16;
   localparam int COLS       = INPUT_LEN + HIDDEN_LEN;
   localparam int ROWS       = 4 * HIDDEN_LEN;
   localparam int WDEPTH     = ROWS * COLS;

   localparam int X_W     = (INPUT_LEN > 1) ? $clog2(INPUT_LEN) : 1;
   localparam int H_W     = (HIDDEN_LEN > 1) ? $clog2(HIDDEN_LEN) : 1;
   localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

   localparam logic [62:0] ONE62 = 63'(64'd1 << 62);
   localparam logic [50:0] ONE50 = 51'(64'd1 << 50);
   localparam logic [62:0] EXP_BASE = 63'((64'd1 << 62) - (64'd1 << 50) + (64'd1 << 37)
                                      - ((64'd1 << 26) / 64'd6) + ((64'd1 << 14) / 64'd24));

   localparam logic signed [15:0] BIAS_FORGET = 16'sd8192;
   localparam logic signed [15:0] BIAS_INPUT  = -16'sd8192;

   typedef enum logic [1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_PUSH   = 2'd2,
      OP_CLEAR  = 2'd3
   } lcf_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC_RD,
      ST_MAC_ACC,
      ST_MAC_END,
      ST_GATE_RD,
      ST_GATE_GO,
      ST_GATE_WAIT,
      ST_CELL_MUL1,
      ST_CELL_MUL2,
      ST_CELL_SUM,
      ST_TANH_GO,
      ST_TANH_WAIT,
      ST_HID_MUL,
      ST_EMIT
   } lcf_state_type;

   typedef enum logic [2:0] {
      ACT_IDLE,
      ACT_STEP,
      ACT_MUL,
      ACT_WB,
      ACT_DSET,
      ACT_DIV,
      ACT_DONE
   } lcf_act_state_type;

   // q17.24 to q4.12, round half up, saturate
   function automatic logic signed [15:0] round_sat(input logic signed [40:0] v);
      logic signed [41:0] t;
      logic signed [29:0] s;
      t = 42'(v) + 42'sd2048;
      s = $signed(t[41:12]);
      if (s > 30'sd32767) begin
         return 16'sh7fff;
      end else if (s < -30'sd32768) begin
         return -16'sd32768;
      end
      return 16'(s);
   endfunction

endpackage

// File: rtl/lcf_act.sv
// lcf_act: sigmoid and tanh in q4.12 by exp (square and multiply on 63-bit
// fixed point, 32x32 partial products) and a restoring divider; uses lcf_pkg
module lcf_act (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [15:0]  x,
   input  logic                use_tanh,
   output logic                done,
   output logic signed [13:0]  y
);

   lcf_pkg::lcf_act_state_type state_ff, state_in;

   logic [16:0]  n_ff;
   logic         neg_ff;
   logic         tanh_ff;
   logic [62:0]  r_ff;
   logic [62:0]  base_ff;
   logic [62:0]  mul_a_ff;
   logic [62:0]  mul_b_ff;
   logic         tgt_r_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic [125:0] acc_ff;
   logic [64:0]  rem_ff;
   logic [64:0]  dsr_ff;
   logic [12:0]  q_ff;
   logic [3:0]   div_cnt_ff;

   logic signed [16:0] xs;
   logic [16:0]  ax;
   logic [31:0]  ah, al, bh, bl;
   logic [63:0]  pp;
   logic [1:0]   sh;
   logic [125:0] acc_add;
   logic [62:0]  mul_res;
   logic [50:0]  e_val;
   logic [51:0]  den;
   logic [50:0]  num;

   always_comb begin
      xs = 17'(x);
      ax = x[15] ? 17'(-xs) : 17'(xs);
      ah = {1'b0, mul_a_ff[62:32]};
      al = mul_a_ff[31:0];
      bh = {1'b0, mul_b_ff[62:32]};
      bl = mul_b_ff[31:0];
      case (cnt_ff)
         3'd0: begin
            pp = 64'(al) * 64'(bl);
            sh = 2'd0;
         end
         3'd1: begin
            pp = 64'(ah) * 64'(bl);
            sh = 2'd1;
         end
         3'd2: begin
            pp = 64'(al) * 64'(bh);
            sh = 2'd1;
         end
         default: begin
            pp = 64'(ah) * 64'(bh);
            sh = 2'd2;
         end
      endcase
      case (sh_ff)
         2'd0:    acc_add = acc_ff + 126'(pp_ff);
         2'd1:    acc_add = acc_ff + (126'(pp_ff) << 32);
         default: acc_add = acc_ff + (126'(pp_ff) << 64);
      endcase
      mul_res = acc_ff[124:62];
      e_val = r_ff[62:12];
      den = 52'(lcf_pkg::ONE50) + 52'(e_val);
      if (tanh_ff) begin
         num = lcf_pkg::ONE50 - e_val;
      end else if (neg_ff) begin
         num = e_val;
      end else begin
         num = lcf_pkg::ONE50;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcf_pkg::ACT_IDLE: if (start) state_in = lcf_pkg::ACT_STEP;
         lcf_pkg::ACT_STEP: state_in = (n_ff == '0) ? lcf_pkg::ACT_DSET : lcf_pkg::ACT_MUL;
         lcf_pkg::ACT_MUL:  if (cnt_ff == 3'd4) state_in = lcf_pkg::ACT_WB;
         lcf_pkg::ACT_WB:   state_in = lcf_pkg::ACT_STEP;
         lcf_pkg::ACT_DSET: state_in = lcf_pkg::ACT_DIV;
         lcf_pkg::ACT_DIV:  if (div_cnt_ff == 4'd12) state_in = lcf_pkg::ACT_DONE;
         lcf_pkg::ACT_DONE: state_in = lcf_pkg::ACT_IDLE;
         default:           state_in = lcf_pkg::ACT_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == lcf_pkg::ACT_DONE);
      y = (neg_ff && tanh_ff) ? -$signed(14'(q_ff)) : $signed(14'(q_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcf_pkg::ACT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         lcf_pkg::ACT_IDLE: begin
            if (start) begin
               n_ff    <= use_tanh ? {ax[15:0], 1'b0} : ax;
               neg_ff  <= x[15];
               tanh_ff <= use_tanh;
               r_ff    <= lcf_pkg::ONE62;
               base_ff <= lcf_pkg::EXP_BASE;
            end
         end
         lcf_pkg::ACT_STEP: begin
            mul_a_ff <= n_ff[0] ? r_ff : base_ff;
            mul_b_ff <= base_ff;
            tgt_r_ff <= n_ff[0];
            cnt_ff   <= 3'd0;
            acc_ff   <= '0;
         end
         lcf_pkg::ACT_MUL: begin
            if (cnt_ff != 3'd4) begin
               pp_ff <= pp;
               sh_ff <= sh;
            end
            if (cnt_ff != 3'd0) begin
               acc_ff <= acc_add;
            end
            cnt_ff <= cnt_ff + 3'd1;
         end
         lcf_pkg::ACT_WB: begin
            if (tgt_r_ff) begin
               r_ff    <= mul_res;
               n_ff[0] <= 1'b0;
            end else begin
               base_ff <= mul_res;
               n_ff    <= n_ff >> 1;
            end
         end
         lcf_pkg::ACT_DSET: begin
            rem_ff     <= (65'(num) << 13) + 65'(den);
            dsr_ff     <= 65'(den) << 13;
            q_ff       <= '0;
            div_cnt_ff <= '0;
         end
         lcf_pkg::ACT_DIV: begin
            if (rem_ff >= dsr_ff) begin
               rem_ff <= rem_ff - dsr_ff;
               q_ff   <= {q_ff[11:0], 1'b1};
            end else begin
               q_ff   <= {q_ff[11:0], 1'b0};
            end
            dsr_ff     <= dsr_ff >> 1;
            div_cnt_ff <= div_cnt_ff + 4'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/lstm_cell_forward_step_core.sv
// lstm_cell_forward_step_core: one lstm time step over q4.12 weights, bias, x, h and c
// held in synchronous memories; uses lcf_pkg and lcf_act
// a weight, bias, clear or non-final x transfer is taken only while idle and leaves busy low;
// the final x element starts a step: 64 rows, each a read and an accumulate state per column
// and a row end state, then five activations in lcf_act per hidden element (four gates, tanh of c)
// results: one per hidden element with no stall; no transfer is taken while busy
// reset: control, bias valid bits and h/c valid bits clear; no clearing pass
module lstm_cell_forward_step_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [10:0]        req_index,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_hidden_value,
   output logic [5:0]         rsp_hidden_index,
   output logic               rsp_last
);

   localparam int ROWS       = lcf_pkg::ROWS;
   localparam int COLS       = lcf_pkg::COLS;
   localparam int INPUT_LEN  = lcf_pkg::INPUT_LEN;
   localparam int HIDDEN_LEN = lcf_pkg::HIDDEN_LEN;

   lcf_pkg::lcf_state_type state_ff, state_in;
   lcf_pkg::lcf_op_type    op;

   logic signed [15:0] w_mem    [lcf_pkg::WDEPTH];
   logic signed [15:0] bias_mem [ROWS];
   logic signed [15:0] pre_mem  [ROWS];
   logic signed [15:0] x_mem    [INPUT_LEN];
   logic signed [15:0] hid_mem  [HIDDEN_LEN];
   logic signed [15:0] cell_mem [HIDDEN_LEN];

   logic signed [15:0] w_rd_ff, bias_rd_ff, pre_rd_ff, x_rd_ff, hid_rd_ff, cell_rd_ff;

   logic [ROWS-1:0]       bias_valid_ff;
   logic [HIDDEN_LEN-1:0] hc_valid_ff;

   logic [lcf_pkg::ROW_W-1:0] row_ff;
   logic [lcf_pkg::COL_W-1:0] col_ff;
   logic [lcf_pkg::H_W-1:0]   hid_i_ff;
   logic [1:0]                gate_k_ff;
   logic signed [39:0]        acc_ff;
   logic signed [13:0]        f_ff, ig_ff, o_ff, g_ff, th_ff;
   logic signed [29:0]        prod_a_ff, prod_b_ff;
   logic signed [15:0]        c_new_ff;
   logic                      rsp_valid_ff;
   logic signed [15:0]        rsp_value_ff;
   logic [5:0]                rsp_index_ff;
   logic                      rsp_last_ff;

   logic accept, w_we, b_we, x_we, step_go, clear_hc, pre_we, hc_we;
   logic act_start, act_tanh, act_done;
   logic signed [15:0] act_x;
   logic signed [13:0] act_y;

   logic [lcf_pkg::WADDR_W-1:0] w_raddr;
   logic [lcf_pkg::ROW_W-1:0]   pre_raddr;
   logic [lcf_pkg::X_W-1:0]     x_raddr;
   logic [lcf_pkg::H_W-1:0]     h_raddr;
   logic signed [15:0] bias_eff, xh_val, cprev, h_new;
   logic signed [39:0] bias_term, acc_base;
   logic signed [31:0] prod;

   always_comb begin
      op       = lcf_pkg::lcf_op_type'(req_opcode);
      busy     = (state_ff != lcf_pkg::ST_IDLE);
      accept   = start && !busy;
      w_we     = accept && (op == lcf_pkg::OP_WEIGHT) && (int'(req_index) < lcf_pkg::WDEPTH);
      b_we     = accept && (op == lcf_pkg::OP_BIAS) && (int'(req_index) < ROWS);
      x_we     = accept && (op == lcf_pkg::OP_PUSH) && (int'(req_index) < INPUT_LEN);
      step_go  = x_we && (int'(req_index) == INPUT_LEN - 1);
      clear_hc = accept && (op == lcf_pkg::OP_CLEAR);

      w_raddr   = lcf_pkg::WADDR_W'(int'(row_ff) * COLS + int'(col_ff));
      pre_raddr = lcf_pkg::ROW_W'(int'(gate_k_ff) * HIDDEN_LEN + int'(hid_i_ff));
      x_raddr   = lcf_pkg::X_W'(col_ff);
      h_raddr   = lcf_pkg::H_W'(int'(col_ff) - INPUT_LEN);

      if (bias_valid_ff[row_ff]) begin
         bias_eff = bias_rd_ff;
      end else if (int'(row_ff) < HIDDEN_LEN) begin
         bias_eff = lcf_pkg::BIAS_FORGET;
      end else if (int'(row_ff) < 2 * HIDDEN_LEN) begin
         bias_eff = lcf_pkg::BIAS_INPUT;
      end else begin
         bias_eff = '0;
      end
      bias_term = 40'(bias_eff) <<< 12;
      acc_base  = (col_ff == '0) ? bias_term : acc_ff;

      if (int'(col_ff) < INPUT_LEN) begin
         xh_val = x_rd_ff;
      end else if (hc_valid_ff[h_raddr]) begin
         xh_val = hid_rd_ff;
      end else begin
         xh_val = '0;
      end
      prod  = 32'(w_rd_ff) * 32'(xh_val);
      cprev = hc_valid_ff[hid_i_ff] ? cell_rd_ff : '0;
      h_new = lcf_pkg::round_sat(41'(prod_a_ff));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcf_pkg::ST_IDLE:      if (step_go) state_in = lcf_pkg::ST_MAC_RD;
         lcf_pkg::ST_MAC_RD:    state_in = lcf_pkg::ST_MAC_ACC;
         lcf_pkg::ST_MAC_ACC: begin
            state_in = (int'(col_ff) == COLS - 1) ? lcf_pkg::ST_MAC_END : lcf_pkg::ST_MAC_RD;
         end
         lcf_pkg::ST_MAC_END: begin
            state_in = (int'(row_ff) == ROWS - 1) ? lcf_pkg::ST_GATE_RD : lcf_pkg::ST_MAC_RD;
         end
         lcf_pkg::ST_GATE_RD:   state_in = lcf_pkg::ST_GATE_GO;
         lcf_pkg::ST_GATE_GO:   state_in = lcf_pkg::ST_GATE_WAIT;
         lcf_pkg::ST_GATE_WAIT: begin
            if (act_done) begin
               state_in = (gate_k_ff == 2'd3) ? lcf_pkg::ST_CELL_MUL1 : lcf_pkg::ST_GATE_RD;
            end
         end
         lcf_pkg::ST_CELL_MUL1: state_in = lcf_pkg::ST_CELL_MUL2;
         lcf_pkg::ST_CELL_MUL2: state_in = lcf_pkg::ST_CELL_SUM;
         lcf_pkg::ST_CELL_SUM:  state_in = lcf_pkg::ST_TANH_GO;
         lcf_pkg::ST_TANH_GO:   state_in = lcf_pkg::ST_TANH_WAIT;
         lcf_pkg::ST_TANH_WAIT: if (act_done) state_in = lcf_pkg::ST_HID_MUL;
         lcf_pkg::ST_HID_MUL:   state_in = lcf_pkg::ST_EMIT;
         lcf_pkg::ST_EMIT: begin
            state_in = (int'(hid_i_ff) == HIDDEN_LEN - 1) ? lcf_pkg::ST_IDLE
                                                          : lcf_pkg::ST_GATE_RD;
         end
         default:               state_in = lcf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      act_start = (state_ff == lcf_pkg::ST_GATE_GO) || (state_ff == lcf_pkg::ST_TANH_GO);
      act_tanh  = (state_ff == lcf_pkg::ST_TANH_GO) || (gate_k_ff == 2'd3);
      act_x     = (state_ff == lcf_pkg::ST_TANH_GO) ? c_new_ff : pre_rd_ff;
      pre_we    = (state_ff == lcf_pkg::ST_MAC_END);
      hc_we     = (state_ff == lcf_pkg::ST_EMIT);
   end

   lcf_act u_act (
      .clock    (clock),
      .reset    (reset),
      .start    (act_start),
      .x        (act_x),
      .use_tanh (act_tanh),
      .done     (act_done),
      .y        (act_y)
   );

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (w_we) w_mem[lcf_pkg::WADDR_W'(req_index)] <= req_value;
      w_rd_ff <= w_mem[w_raddr];
      if (b_we) bias_mem[lcf_pkg::ROW_W'(req_index)] <= req_value;
      bias_rd_ff <= bias_mem[row_ff];
      if (pre_we) pre_mem[row_ff] <= lcf_pkg::round_sat(41'(acc_ff));
      pre_rd_ff <= pre_mem[pre_raddr];
      if (x_we) x_mem[lcf_pkg::X_W'(req_index)] <= req_value;
      x_rd_ff <= x_mem[x_raddr];
      if (hc_we) hid_mem[hid_i_ff] <= h_new;
      hid_rd_ff <= hid_mem[h_raddr];
      if (hc_we) cell_mem[hid_i_ff] <= c_new_ff;
      cell_rd_ff <= cell_mem[hid_i_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lcf_pkg::ST_IDLE;
         bias_valid_ff <= '0;
         hc_valid_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= hc_we;
         if (b_we) bias_valid_ff[lcf_pkg::ROW_W'(req_index)] <= 1'b1;
         if (clear_hc) begin
            hc_valid_ff <= '0;
         end else if (hc_we) begin
            hc_valid_ff[hid_i_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         lcf_pkg::ST_IDLE: begin
            row_ff <= '0;
            col_ff <= '0;
         end
         lcf_pkg::ST_MAC_ACC: begin
            acc_ff <= acc_base + 40'(prod);
            col_ff <= (int'(col_ff) == COLS - 1) ? '0 : col_ff + 1'b1;
         end
         lcf_pkg::ST_MAC_END: begin
            row_ff    <= row_ff + 1'b1;
            hid_i_ff  <= '0;
            gate_k_ff <= '0;
         end
         lcf_pkg::ST_GATE_WAIT: begin
            if (act_done) begin
               case (gate_k_ff)
                  2'd0:    f_ff  <= act_y;
                  2'd1:    ig_ff <= act_y;
                  2'd2:    o_ff  <= act_y;
                  default: g_ff  <= act_y;
               endcase
               gate_k_ff <= gate_k_ff + 2'd1;
            end
         end
         lcf_pkg::ST_CELL_MUL1: prod_a_ff <= 30'(f_ff) * 30'(cprev);
         lcf_pkg::ST_CELL_MUL2: prod_b_ff <= 30'(ig_ff) * 30'(g_ff);
         lcf_pkg::ST_CELL_SUM:  c_new_ff <= lcf_pkg::round_sat(41'(prod_a_ff) + 41'(prod_b_ff));
         lcf_pkg::ST_TANH_WAIT: if (act_done) th_ff <= act_y;
         lcf_pkg::ST_HID_MUL:   prod_a_ff <= 30'(o_ff) * 30'(th_ff);
         lcf_pkg::ST_EMIT: begin
            rsp_value_ff <= h_new;
            rsp_index_ff <= 6'(hid_i_ff);
            rsp_last_ff  <= (int'(hid_i_ff) == HIDDEN_LEN - 1);
            hid_i_ff     <= hid_i_ff + 1'b1;
            gate_k_ff    <= '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hidden_value = rsp_value_ff;
   assign rsp_hidden_index = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;

   a_mid_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("result transfer before last while idle");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> int'(rsp_hidden_index) == HIDDEN_LEN - 1)
      else $error("last flag on wrong hidden element");

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      step_go |=> busy)
      else $error("final x transfer did not start a step");

   a_act_done_expected: assert property (@(posedge clock) disable iff (reset)
      act_done |-> state_ff == lcf_pkg::ST_GATE_WAIT || state_ff == lcf_pkg::ST_TANH_WAIT)
      else $error("activation finished outside a wait state");

endmodule

// File: verif/lstm_cell_forward_step_core_tb.sv
// lstm_cell_forward_step_core_tb: self-checking bench for one lstm forward time step,
// directed rows then random weight, bias, clear and x transfers checked by a q4.12 predictor
// depends on lcf_pkg and lstm_cell_forward_step_core
module lstm_cell_forward_step_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 260;
   localparam longint CYCLE_LIMIT = 25_000_000;

   localparam int WDEPTH     = lcf_pkg::WDEPTH;
   localparam int ROWS       = lcf_pkg::ROWS;
   localparam int COLS       = lcf_pkg::COLS;
   localparam int INPUT_LEN  = lcf_pkg::INPUT_LEN;
   localparam int HIDDEN_LEN = lcf_pkg::HIDDEN_LEN;

   typedef struct {
      logic signed [15:0] value;
      logic [5:0]         index;
      logic               last;
   } hidden_elem_type;

   typedef struct {
      lcf_pkg::lcf_op_type op;
      logic [10:0]         index;
      logic signed [15:0]  value;
      bit                  zero_h;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic [10:0]        req_index;
   logic signed [15:0] req_value;
   logic               rsp_valid;
   logic signed [15:0] rsp_hidden_value;
   logic [5:0]         rsp_hidden_index;
   logic               rsp_last;

   logic signed [15:0] weights [WDEPTH];
   logic signed [15:0] biases [ROWS];
   logic signed [15:0] x_elems [INPUT_LEN];
   logic signed [15:0] h_elems [HIDDEN_LEN];
   logic signed [15:0] c_elems [HIDDEN_LEN];
   hidden_elem_type    hidden_q [$];
   int                 error_count = 0;
   int                 sent_count = 0;
   int                 gap_pct = 0;
   longint             cycle_count = 0;

   lstm_cell_forward_step_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_index(req_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_hidden_value(rsp_hidden_value),
      .rsp_hidden_index(rsp_hidden_index), .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int q24_to_q12(longint v);
      longint r;
      r = (v + 2048) >>> 12;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
   endfunction

   // e^(-n/4096) as q0.50, square and multiply at q0.62
   function automatic bit [63:0] exp_decay50(int unsigned n);
      bit [63:0]  base;
      bit [63:0]  acc;
      bit [127:0] p;
      base = (64'd1 << 62) - (64'd1 << 50) + (64'd1 << 37)
             - ((64'd1 << 26) / 64'd6) + ((64'd1 << 14) / 64'd24);
      acc = 64'd1 << 62;
      while (n != 0) begin
         if (n[0]) begin
            p = {64'd0, acc} * {64'd0, base};
            acc = 64'(p >> 62);
         end
         p = {64'd0, base} * {64'd0, base};
         base = 64'(p >> 62);
         n = n >> 1;
      end
      return acc >> 12;
   endfunction

   function automatic int q12_ratio(bit [63:0] num, bit [63:0] den);
      return int'((num * 64'd8192 + den) / (64'd2 * den));
   endfunction

   function automatic int sigmoid_q12(int x);
      bit [63:0] e;
      e = exp_decay50(int'(x < 0 ? -x : x));
      return q12_ratio(x >= 0 ? (64'd1 << 50) : e, (64'd1 << 50) + e);
   endfunction

   function automatic int tanh_q12(int x);
      bit [63:0] e;
      int r;
      e = exp_decay50(int'(x < 0 ? -x : x) * 2);
      r = q12_ratio((64'd1 << 50) - e, (64'd1 << 50) + e);
      return x < 0 ? -r : r;
   endfunction

   task automatic reset_model();
      for (int r = 0; r < ROWS; r++) begin
         biases[r] = (r < HIDDEN_LEN) ? 16'sd8192 : (r < 2 * HIDDEN_LEN) ? -16'sd8192 : 16'sd0;
      end
      for (int j = 0; j < HIDDEN_LEN; j++) begin
         h_elems[j] = '0;
         c_elems[j] = '0;
      end
      for (int j = 0; j < INPUT_LEN; j++) x_elems[j] = '0;
      for (int j = 0; j < WDEPTH; j++) weights[j] = '0;
   endtask

   task automatic run_time_step();
      longint             acc;
      int                 pre [ROWS];
      logic signed [15:0] xh [COLS];
      int                 f, ig, o, g, c, h;
      hidden_elem_type    e;
      for (int j = 0; j < INPUT_LEN; j++) xh[j] = x_elems[j];
      for (int j = 0; j < HIDDEN_LEN; j++) xh[INPUT_LEN + j] = h_elems[j];
      for (int r = 0; r < ROWS; r++) begin
         acc = longint'(biases[r]) * 4096;
         for (int j = 0; j < COLS; j++) acc += longint'(weights[r * COLS + j]) * longint'(xh[j]);
         pre[r] = q24_to_q12(acc);
      end
      for (int i = 0; i < HIDDEN_LEN; i++) begin
         f  = sigmoid_q12(pre[i]);
         ig = sigmoid_q12(pre[HIDDEN_LEN + i]);
         o  = sigmoid_q12(pre[2 * HIDDEN_LEN + i]);
         g  = tanh_q12(pre[3 * HIDDEN_LEN + i]);
         c  = q24_to_q12(longint'(f) * longint'(c_elems[i]) + longint'(ig) * longint'(g));
         h  = q24_to_q12(longint'(o) * longint'(tanh_q12(c)));
         c_elems[i] = 16'(c);
         h_elems[i] = 16'(h);
         e.value = 16'(h);
         e.index = 6'(i);
         e.last  = (i == HIDDEN_LEN - 1);
         hidden_q = {hidden_q, e};
      end
   endtask

   task automatic apply_transfer(lcf_pkg::lcf_op_type op, logic [10:0] idx,
                                 logic signed [15:0] val);
      case (op)
         lcf_pkg::OP_WEIGHT: begin
            if (int'(idx) < WDEPTH) weights[idx] = val;
         end
         lcf_pkg::OP_BIAS: begin
            if (int'(idx) < ROWS) biases[idx] = val;
         end
         lcf_pkg::OP_CLEAR: begin
            for (int j = 0; j < HIDDEN_LEN; j++) begin
               h_elems[j] = '0;
               c_elems[j] = '0;
            end
         end
         default: begin
            if (int'(idx) < INPUT_LEN) begin
               x_elems[idx] = val;
               if (int'(idx) == INPUT_LEN - 1) run_time_step();
            end
         end
      endcase
   endtask

   task automatic send(lcf_pkg::lcf_op_type op, logic [10:0] idx, logic signed [15:0] val);
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_index = idx;
      req_value = val;
      do @(posedge clock); while (busy);
      apply_transfer(op, idx, val);
      sent_count++;
      if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
         @(negedge clock);
         start = 1'b0;
         req_value = 16'($urandom);
         repeat ($urandom_range(4, 0)) @(negedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_weight();
      if ($urandom_range(3, 0) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(767, 0)) - 384);
   endfunction

   always @(posedge clock) begin
      hidden_elem_type e;
      if (!reset && rsp_valid) begin
         if (hidden_q.size() == 0) begin
            $error("unexpected result transfer index %0d", rsp_hidden_index);
            error_count++;
         end else begin
            e = hidden_q.pop_front();
            if (rsp_hidden_value !== e.value) begin
               $error("hidden_value expected %0d actual %0d", e.value, rsp_hidden_value);
               error_count++;
            end
            if (rsp_hidden_index !== e.index) begin
               $error("hidden_index expected %0d actual %0d", e.index, rsp_hidden_index);
               error_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   stim_row_type dir_rows [24] = '{
      '{lcf_pkg::OP_BIAS,   11'd64,   16'sd0,      1'b0},
      '{lcf_pkg::OP_BIAS,   11'd2047, 16'sd1234,   1'b0},
      '{lcf_pkg::OP_PUSH,   11'd16,   16'sd4096,   1'b0},
      '{lcf_pkg::OP_PUSH,   11'd2047, -16'sd4096,  1'b0},
      '{lcf_pkg::OP_CLEAR,  11'd0,    16'sd0,      1'b0},
      '{lcf_pkg::OP_PUSH,   11'd0,    16'sd32767,  1'b0},
      '{lcf_pkg::OP_PUSH,   11'd1,    -16'sd32768, 1'b0},
      '{lcf_pkg::OP_PUSH,   11'd2,    16'sd0,      1'b0},
      '{lcf_pkg::OP_PUSH,   11'd3,    -16'sd1,     1'b0},
      '{lcf_pkg::OP_PUSH,   11'd4,    16'sd1,      1'b0},
      '{lcf_pkg::OP_PUSH,   11'd5,    16'sd4096,   1'b0},
      '{lcf_pkg::OP_PUSH,   11'd6,    -16'sd4096,  1'b0},
      '{lcf_pkg::OP_PUSH,   11'd7,    16'sd21845,  1'b0},
      '{lcf_pkg::OP_PUSH,   11'd8,    -16'sd21846, 1'b0},
      '{lcf_pkg::OP_PUSH,   11'd9,    16'sd32767,  1'b0},
      '{lcf_pkg::OP_PUSH,   11'd10,   -16'sd32768, 1'b0},
      '{lcf_pkg::OP_PUSH,   11'd11,   16'sd2048,   1'b0},
      '{lcf_pkg::OP_PUSH,   11'd12,   -16'sd2048,  1'b0},
      '{lcf_pkg::OP_PUSH,   11'd13,   16'sd100,    1'b0},
      '{lcf_pkg::OP_PUSH,   11'd14,   -16'sd100,   1'b0},
      '{lcf_pkg::OP_PUSH,   11'd15,   16'sd32767,  1'b1},
      '{lcf_pkg::OP_WEIGHT, 11'd2047, 16'sd32767,  1'b0},
      '{lcf_pkg::OP_BIAS,   11'd63,   -16'sd32768, 1'b0},
      '{lcf_pkg::OP_PUSH,   11'd15,   -16'sd32768, 1'b0}
   };

   initial begin
      int depth;
      int kind;
      int phase_len;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = lcf_pkg::OP_WEIGHT;
      req_index = '0;
      req_value = '0;
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every weight written once, all zero so the first step gives h = 0
      for (int j = 0; j < WDEPTH; j++) send(lcf_pkg::OP_WEIGHT, 11'(j), 16'sd0);

      foreach (dir_rows[k]) begin
         depth = hidden_q.size();
         send(dir_rows[k].op, dir_rows[k].index, dir_rows[k].value);
         if (dir_rows[k].zero_h) begin
            for (int j = depth; j < hidden_q.size(); j++) hidden_q[j].value = '0;
         end
      end

      // random weights so the gates move before the random part
      for (int j = 0; j < WDEPTH; j++) send(lcf_pkg::OP_WEIGHT, 11'(j), rand_weight());

      sent_count = 0;
      phase_len = RANDOM_ITEMS / 3;
      while (sent_count < RANDOM_ITEMS) begin
         gap_pct = (sent_count < phase_len) ? 9 : (sent_count < 2 * phase_len) ? 80 : 0;
         kind = $urandom_range(99, 0);
         if (kind < 25) begin
            // well-formed x vector, one time step
            for (int j = 0; j < INPUT_LEN; j++) send(lcf_pkg::OP_PUSH, 11'(j), rand_weight());
         end else if (kind < 55) begin
            send(lcf_pkg::OP_WEIGHT, 11'($urandom_range(2047, 0)), rand_weight());
         end else if (kind < 70) begin
            send(lcf_pkg::OP_BIAS, ($urandom_range(4, 0) == 0) ? 11'($urandom_range(2047, 0))
                                                               : 11'($urandom_range(ROWS - 1, 0)),
                 rand_weight());
         end else if (kind < 76) begin
            send(lcf_pkg::OP_CLEAR, 11'($urandom), 16'($urandom));
         end else if (kind < 84) begin
            send(lcf_pkg::OP_PUSH, 11'($urandom_range(2047, INPUT_LEN)), 16'($urandom));
         end else if (kind < 97) begin
            send(lcf_pkg::OP_PUSH, 11'($urandom_range(INPUT_LEN - 2, 0)), 16'($urandom));
         end else begin
            send(lcf_pkg::OP_PUSH, 11'(INPUT_LEN - 1), rand_weight());
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (hidden_q.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
